// File: design/rilp_pkg.sv
package rilp_pkg;

  localparam int DEFAULT_VALUE_WIDTH = 32;

  typedef enum logic [1:0] {
    PH_START,
    PH_SIGNED,
    PH_ZERO,
    PH_DIGITS
  } phase_t;

  localparam logic [1:0] RADIX_BIN = 2'd0;
  localparam logic [1:0] RADIX_OCT = 2'd1;
  localparam logic [1:0] RADIX_DEC = 2'd2;
  localparam logic [1:0] RADIX_HEX = 2'd3;

  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UF    = 8'h46;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LF    = 8'h66;
  localparam logic [7:0] CH_LX    = 8'h78;
  localparam logic [7:0] CH_UX    = 8'h58;
  localparam logic [7:0] CH_LH    = 8'h68;
  localparam logic [7:0] CH_UH    = 8'h48;
  localparam logic [7:0] CH_LQ    = 8'h71;
  localparam logic [7:0] CH_UQ    = 8'h51;
  localparam logic [7:0] CH_LO    = 8'h6F;
  localparam logic [7:0] CH_UO    = 8'h4F;
  localparam logic [7:0] CH_LB    = 8'h62;
  localparam logic [7:0] CH_UB    = 8'h42;
  localparam logic [7:0] CH_LD    = 8'h64;
  localparam logic [7:0] CH_UD    = 8'h44;

  typedef struct packed {
    logic       stopped;
    logic       on_last;
    logic [7:0] at;
  } lane_stat_t;

  function automatic logic [4:0] radix_of(input logic [1:0] code);
    logic [4:0] r;
    case (code)
      RADIX_BIN: r = 5'd2;
      RADIX_OCT: r = 5'd8;
      RADIX_DEC: r = 5'd10;
      default:   r = 5'd16;
    endcase
    return r;
  endfunction

  function automatic logic is_hex(input logic [7:0] c);
    return (c >= CH_ZERO && c <= CH_NINE) || (c >= CH_LA && c <= CH_LF) ||
           (c >= CH_UA && c <= CH_UF);
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [7:0] v;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      v = c - CH_ZERO;
    end else if (c <= CH_UF) begin
      v = c - CH_UA + 8'd10;
    end else begin
      v = c - CH_LA + 8'd10;
    end
    return v[3:0];
  endfunction

endpackage

// File: design/radix_integer_literal_parser.sv
// Latency: a result item is valid in the cycle after its terminator is accepted.
// Throughput: one character per cycle; the four radix lanes update in parallel
// with one shift-and-add each; input holds only while a result item waits with out_ready low.
// Reset (synchronous, active low): token state and lanes cleared, parser
// waits for the first character, no result pending.
module radix_integer_literal_parser #(
  parameter int VALUE_WIDTH = rilp_pkg::DEFAULT_VALUE_WIDTH
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [7:0]                    in_ch,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [VALUE_WIDTH-1:0] out_value,
  output logic [7:0]                    out_consumed,
  output logic [1:0]                    out_radix_code
);

  rilp_pkg::phase_t phase_r, phase_nxt, eph;

  logic       neg_r, sign_r, hexp_r, first0_r, last_b_r, last_d_r;
  logic [7:0] cc_r;
  logic [1:0] dc_r;

  logic       accept, c_hex, c_sign, c_x, c_h, c_q;
  logic       is_sign, take, hex_pfx, fin;
  logic [3:0] digit;

  logic [VALUE_WIDTH-1:0] lane_acc  [4];
  logic [VALUE_WIDTH-1:0] lane_prev [4];
  rilp_pkg::lane_stat_t   lane_st   [4];

  logic                   out_valid_r;
  logic [VALUE_WIDTH-1:0] out_value_r;
  logic [7:0]             out_consumed_r;
  logic [1:0]             out_radix_r;

  logic [1:0]             fin_bi;
  logic [VALUE_WIDTH-1:0] fin_mag;
  logic [7:0]             fin_end, start_pos;
  logic                   suffix, special;

  function automatic logic [7:0] sat_inc(input logic [7:0] v);
    return (v == 8'hFF) ? v : v + 8'd1;
  endfunction

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  assign c_hex  = rilp_pkg::is_hex(in_ch);
  assign c_sign = (in_ch == rilp_pkg::CH_MINUS) || (in_ch == rilp_pkg::CH_PLUS);
  assign c_x    = (in_ch == rilp_pkg::CH_LX) || (in_ch == rilp_pkg::CH_UX);
  assign c_h    = (in_ch == rilp_pkg::CH_LH) || (in_ch == rilp_pkg::CH_UH);
  assign c_q    = (in_ch == rilp_pkg::CH_LQ) || (in_ch == rilp_pkg::CH_UQ) ||
                  (in_ch == rilp_pkg::CH_LO) || (in_ch == rilp_pkg::CH_UO);
  assign digit  = rilp_pkg::hex_val(in_ch);

  // a non-sign first character is handled as if a sign had been passed
  assign eph = (phase_r == rilp_pkg::PH_START) ? rilp_pkg::PH_SIGNED : phase_r;

  always_comb begin
    is_sign = 1'b0;
    take    = 1'b0;
    hex_pfx = 1'b0;
    fin     = 1'b0;
    if (accept) begin
      if (phase_r == rilp_pkg::PH_START && c_sign) begin
        is_sign = 1'b1;
      end else if (c_hex) begin
        take = 1'b1;
      end else if (phase_r == rilp_pkg::PH_ZERO && c_x) begin
        hex_pfx = 1'b1;
      end else begin
        fin = 1'b1;
      end
    end
  end

  always_comb begin
    phase_nxt = phase_r;
    if (is_sign) begin
      phase_nxt = rilp_pkg::PH_SIGNED;
    end else if (fin) begin
      phase_nxt = rilp_pkg::PH_START;
    end else if (hex_pfx) begin
      phase_nxt = rilp_pkg::PH_DIGITS;
    end else if (take) begin
      if (eph == rilp_pkg::PH_SIGNED && in_ch == rilp_pkg::CH_ZERO) begin
        phase_nxt = rilp_pkg::PH_ZERO;
      end else begin
        phase_nxt = rilp_pkg::PH_DIGITS;
      end
    end
  end

  for (genvar g = 0; g < 4; g++) begin : g_lane
    rilp_lane #(
      .VALUE_WIDTH(VALUE_WIDTH),
      .RADIX_CODE (2'(g))
    ) u_lane (
      .clk  (clk),
      .rst_n(rst_n),
      .clear(fin || hex_pfx),
      .take (take),
      .digit(digit),
      .pos  (cc_r),
      .acc  (lane_acc[g]),
      .prev (lane_prev[g]),
      .stat (lane_st[g])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n || fin) begin
      phase_r  <= rilp_pkg::PH_START;
      neg_r    <= 1'b0;
      sign_r   <= 1'b0;
      hexp_r   <= 1'b0;
      first0_r <= 1'b0;
      last_b_r <= 1'b0;
      last_d_r <= 1'b0;
      cc_r     <= '0;
      dc_r     <= '0;
    end else begin
      phase_r <= phase_nxt;
      if (is_sign) begin
        neg_r  <= (in_ch == rilp_pkg::CH_MINUS);
        sign_r <= 1'b1;
        cc_r   <= sat_inc(cc_r);
      end
      if (hex_pfx) begin
        hexp_r   <= 1'b1;
        first0_r <= 1'b0;
        last_b_r <= 1'b0;
        last_d_r <= 1'b0;
        dc_r     <= '0;
        cc_r     <= sat_inc(cc_r);
      end
      if (take) begin
        if (dc_r == 2'd0 && in_ch == rilp_pkg::CH_ZERO) begin
          first0_r <= 1'b1;
        end
        last_b_r <= (in_ch == rilp_pkg::CH_LB) || (in_ch == rilp_pkg::CH_UB);
        last_d_r <= (in_ch == rilp_pkg::CH_LD) || (in_ch == rilp_pkg::CH_UD);
        if (dc_r != 2'd2) begin
          dc_r <= dc_r + 2'd1;
        end
        cc_r <= sat_inc(cc_r);
      end
    end
  end

  assign start_pos = {6'd0, hexp_r, sign_r};

  always_comb begin
    fin_bi  = rilp_pkg::RADIX_DEC;
    fin_mag = '0;
    fin_end = start_pos;
    suffix  = 1'b0;
    special = 1'b0;
    if (hexp_r) begin
      fin_bi = rilp_pkg::RADIX_HEX;
    end else if (c_h) begin
      fin_bi = rilp_pkg::RADIX_HEX;
      suffix = 1'b1;
    end else if (c_q) begin
      fin_bi = rilp_pkg::RADIX_OCT;
      suffix = 1'b1;
    end else if (dc_r != 2'd0 && first0_r) begin
      fin_bi = rilp_pkg::RADIX_OCT;
    end else if (dc_r != 2'd0 && (last_b_r || last_d_r)) begin
      fin_bi  = last_b_r ? rilp_pkg::RADIX_BIN : rilp_pkg::RADIX_DEC;
      special = 1'b1;
    end
    if (special) begin
      // last digit is a b/d suffix: drop it from the value
      if (dc_r == 2'd1) begin
        fin_end = start_pos;
      end else if (lane_st[fin_bi].stopped && !lane_st[fin_bi].on_last) begin
        fin_mag = lane_acc[fin_bi];
        fin_end = lane_st[fin_bi].at;
      end else begin
        fin_mag = lane_st[fin_bi].stopped ? lane_acc[fin_bi] : lane_prev[fin_bi];
        fin_end = cc_r;
      end
    end else if (dc_r == 2'd0) begin
      fin_end = start_pos;
    end else if (lane_st[fin_bi].stopped) begin
      fin_mag = lane_acc[fin_bi];
      fin_end = lane_st[fin_bi].at;
    end else begin
      fin_mag = lane_acc[fin_bi];
      fin_end = suffix ? sat_inc(cc_r) : cc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fin) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin) begin
      out_value_r    <= neg_r ? ({VALUE_WIDTH{1'b0}} - fin_mag) : fin_mag;
      out_consumed_r <= fin_end;
      out_radix_r    <= fin_bi;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_value      = out_value_r;
  assign out_consumed   = out_consumed_r;
  assign out_radix_code = out_radix_r;

`ifndef NO_ASSERTIONS
  a_fin_clears: assert property (@(posedge clk) disable iff (!rst_n)
    fin |=> phase_r == rilp_pkg::PH_START && cc_r == 8'd0 && !sign_r)
    else $error("token state not cleared after terminator");

  a_no_digit_flags: assert property (@(posedge clk) disable iff (!rst_n)
    dc_r == 2'd0 |-> !first0_r && !last_b_r && !last_d_r)
    else $error("digit flags set with no digits");

  a_hex_phase: assert property (@(posedge clk) disable iff (!rst_n)
    hexp_r |-> phase_r == rilp_pkg::PH_DIGITS)
    else $error("hex prefix outside digit phase");

  a_zero_phase: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == rilp_pkg::PH_ZERO |-> dc_r == 2'd1 && first0_r)
    else $error("leading zero phase without a single zero digit");

  a_result_on_fin: assert property (@(posedge clk) disable iff (!rst_n)
    fin |=> out_valid_r)
    else $error("terminator accepted but no result raised");
`endif

endmodule

// File: design/rilp_lane.sv
module rilp_lane #(
  parameter int VALUE_WIDTH = rilp_pkg::DEFAULT_VALUE_WIDTH,
  parameter logic [1:0] RADIX_CODE = rilp_pkg::RADIX_DEC
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   clear,
  input  logic                   take,
  input  logic [3:0]             digit,
  input  logic [7:0]             pos,
  output logic [VALUE_WIDTH-1:0] acc,
  output logic [VALUE_WIDTH-1:0] prev,
  output rilp_pkg::lane_stat_t   stat
);

  logic [VALUE_WIDTH-1:0] acc_r, acc_nxt;
  logic [VALUE_WIDTH-1:0] prev_r;
  rilp_pkg::lane_stat_t   stat_r;
  logic [VALUE_WIDTH-1:0] scaled;
  logic                   digit_ok;

  always_comb begin
    case (RADIX_CODE)
      rilp_pkg::RADIX_BIN: scaled = acc_r << 1;
      rilp_pkg::RADIX_OCT: scaled = acc_r << 3;
      rilp_pkg::RADIX_DEC: scaled = (acc_r << 3) + (acc_r << 1);
      default:             scaled = acc_r << 4;
    endcase
  end

  assign digit_ok = {1'b0, digit} < rilp_pkg::radix_of(RADIX_CODE);
  assign acc_nxt  = scaled + {{(VALUE_WIDTH-4){1'b0}}, digit};

  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      acc_r  <= '0;
      prev_r <= '0;
      stat_r <= '0;
    end else if (take) begin
      if (!stat_r.stopped) begin
        if (!digit_ok) begin
          // freeze at the first digit this radix cannot hold
          stat_r.stopped <= 1'b1;
          stat_r.on_last <= 1'b1;
          stat_r.at      <= pos;
        end else begin
          stat_r.on_last <= 1'b0;
          prev_r <= acc_r;
          acc_r  <= acc_nxt;
        end
      end else begin
        stat_r.on_last <= 1'b0;
      end
    end
  end

  assign acc  = acc_r;
  assign prev = prev_r;
  assign stat = stat_r;

endmodule
